### src/feature_grid_bin_and_area_query_unit_assert.svh
// Assertion macros for the RTL of the grid unit.
`ifndef FEATURE_GRID_BIN_AND_AREA_QUERY_UNIT_ASSERT_SVH
`define FEATURE_GRID_BIN_AND_AREA_QUERY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FGBQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fgbq assertion failed");
`define FGBQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fgbq implication failed");
`else
`define FGBQ_ASSERT(lbl, clk, rst_n, prop)
`define FGBQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/fgbq_pkg.sv
package fgbq_pkg;

    localparam int GRID_COLS     = 64;
    localparam int GRID_ROWS     = 48;
    localparam int CELL_CAPACITY = 8;
    localparam int MAX_MATCHES   = 64;

    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int ENT_DEPTH = NUM_CELLS * CELL_CAPACITY;
    localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int CNT_W     = $clog2(CELL_CAPACITY + 1);
    localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int MCNT_W    = $clog2(MAX_MATCHES + 1);
    localparam int ENT_W     = 47;

    localparam logic signed [15:0] COL_MAX = 16'(GRID_COLS - 1);
    localparam logic signed [15:0] ROW_MAX = 16'(GRID_ROWS - 1);
    localparam logic signed [35:0] HALF_CELL = 36'sd524288;
    localparam logic signed [35:0] CEIL_ADD  = 36'sd1048575;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEARED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_MATCH    = 3'd4,
        ST_NO_MATCH = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_ORIGIN_X   = 2'd0,
        REG_ORIGIN_Y   = 2'd1,
        REG_CELL_W_INV = 2'd2,
        REG_CELL_H_INV = 2'd3
    } t_reg;

endpackage

### src/fgbq_ram.sv
module fgbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### src/feature_grid_bin_and_area_query_unit.sv
// Feature grid: bins feature points into grid cells and answers square window queries.
// Input channel (s_axis): tuser carries the operation (clear, insert, query), tdata the
// feature index, position, radius, octave and the query's level bounds.
// Output channel (m_axis): tuser carries status and the truncation flag, tdata the
// matching feature index, tlast marks the final result of an input item.
// Configuration: origin and inverse cell sizes must be written by the user through
// i_cfg_* only while idle; the block does not enforce it. One item is worked at a time.
// An insert scales its position to a cell and stores the entry if the cell has room.
// A query scales its low and high window bounds, then walks the cells, reading the
// count memory for each visited cell and the entry memory for each entry. A clear
// sweeps the count memory, one cell a cycle. After reset the same sweep runs and no
// item is accepted until it ends. Results go through one output register; while the
// receiver stalls, the walk holds at the next result and resumes when the register is
// free. A result that another match may follow is held back one step so that tlast and
// the truncation flag are known when it leaves.
`include "feature_grid_bin_and_area_query_unit_assert.svh"

module feature_grid_bin_and_area_query_unit import fgbq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // feature_index[11:0], x_pos[27:12], y_pos[43:28], radius[58:44], octave[61:59],
    // min_level[64:62], max_level[68:65], zero pad[71:69]
    input  logic [71:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // match_index[11:0], zero pad[15:12]
    output logic [15:0] o_m_axis_tdata,
    // status[2:0], truncated[3]
    output logic [3:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_MUL0, S_MUL1, S_RANGE, S_INS_CELL, S_INS_RD, S_INS_WR,
        S_CNT_RD, S_CNT_WAIT, S_ENT_RD, S_ENT_CHK, S_FIN, S_EMIT
    } t_state;

    t_state r_state;

    logic signed [15:0] r_org_x, r_org_y;
    logic [15:0]        r_inv_x, r_inv_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_inv_x <= 16'd6554;
            r_inv_y <= 16'd6554;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_ORIGIN_X:   r_org_x <= i_cfg_data;
                REG_ORIGIN_Y:   r_org_y <= i_cfg_data;
                REG_CELL_W_INV: r_inv_x <= i_cfg_data;
                REG_CELL_H_INV: r_inv_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input fields
    logic [11:0]        in_fidx;
    logic signed [15:0] in_x, in_y;
    logic [14:0]        in_r;
    logic [2:0]         in_oct, in_min;
    logic [3:0]         in_max;
    logic               s_acc;

    assign in_fidx = i_s_axis_tdata[11:0];
    assign in_x    = i_s_axis_tdata[27:12];
    assign in_y    = i_s_axis_tdata[43:28];
    assign in_r    = i_s_axis_tdata[58:44];
    assign in_oct  = i_s_axis_tdata[61:59];
    assign in_min  = i_s_axis_tdata[64:62];
    assign in_max  = i_s_axis_tdata[68:65];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Item registers
    logic [11:0]        r_fidx;
    logic signed [15:0] r_x, r_y;
    logic [16:0]        r_rr;
    logic [2:0]         r_oct, r_min;
    logic [3:0]         r_max;
    logic               r_ins;
    logic signed [17:0] r_dl_x, r_dh_x, r_dl_y, r_dh_y;
    logic signed [34:0] r_pl_x, r_ph_x, r_pl_y, r_ph_y;
    logic               r_clr_reply;
    t_status            r_st;

    logic signed [16:0] dx, dy;
    assign dx = {in_x[15], in_x} - {r_org_x[15], r_org_x};
    assign dy = {in_y[15], in_y} - {r_org_y[15], r_org_y};

    // One multiplier per axis, low bound first, then high bound.
    logic signed [17:0] mul_ax, mul_ay;
    logic signed [16:0] inv_xs, inv_ys;
    logic signed [34:0] prod_x, prod_y;
    assign mul_ax = (r_state == S_MUL1) ? r_dh_x : r_dl_x;
    assign mul_ay = (r_state == S_MUL1) ? r_dh_y : r_dl_y;
    assign inv_xs = $signed({1'b0, r_inv_x});
    assign inv_ys = $signed({1'b0, r_inv_y});
    assign prod_x = mul_ax * inv_xs;
    assign prod_y = mul_ay * inv_ys;

    // Cell arithmetic on registered products
    logic signed [35:0] ins_tx, ins_ty, ceil_tx, ceil_ty;
    logic signed [15:0] cx, cy, lo_x, lo_y, hi_x, hi_y, x0c, x1c, y0c, y1c;
    logic               ins_out, range_empty;
    assign ins_tx  = 36'(r_pl_x) + HALF_CELL;
    assign ins_ty  = 36'(r_pl_y) + HALF_CELL;
    assign cx      = ins_tx[35:20];
    assign cy      = ins_ty[35:20];
    assign ins_out = (cx < 0) || (cx > COL_MAX) || (cy < 0) || (cy > ROW_MAX);
    assign ceil_tx = 36'(r_ph_x) + CEIL_ADD;
    assign ceil_ty = 36'(r_ph_y) + CEIL_ADD;
    assign lo_x    = {r_pl_x[34], r_pl_x[34:20]};
    assign lo_y    = {r_pl_y[34], r_pl_y[34:20]};
    assign hi_x    = ceil_tx[35:20];
    assign hi_y    = ceil_ty[35:20];
    assign x0c     = (lo_x < 0) ? 16'sd0 : lo_x;
    assign y0c     = (lo_y < 0) ? 16'sd0 : lo_y;
    assign x1c     = (hi_x > COL_MAX) ? COL_MAX : hi_x;
    assign y1c     = (hi_y > ROW_MAX) ? ROW_MAX : hi_y;
    assign range_empty = (x0c > COL_MAX) || (x1c < 0) || (x0c > x1c)
                      || (y0c > ROW_MAX) || (y1c < 0) || (y0c > y1c);

    // Walk registers
    logic [COL_W-1:0]   r_ix, r_x0, r_x1;
    logic [ROW_W-1:0]   r_iy, r_y0, r_y1;
    logic [CELL_AW-1:0] r_cell, r_sweep, ins_cell, q_cell;
    logic [CNT_W-1:0]   r_n, r_j;
    logic [MCNT_W-1:0]  r_k;
    logic               r_pend;
    logic [11:0]        r_pidx;
    logic               last_cell, more_slots;

    assign ins_cell = CELL_AW'(cx[COL_W-1:0]) * CELL_AW'(GRID_ROWS) + CELL_AW'(cy[ROW_W-1:0]);
    assign q_cell   = CELL_AW'(r_ix) * CELL_AW'(GRID_ROWS) + CELL_AW'(r_iy);
    assign last_cell  = (r_ix == r_x1) && (r_iy == r_y1);
    assign more_slots = (({1'b0, r_j} + 1'b1) < {1'b0, r_n});

    // Memories
    logic               cnt_we, cnt_re, ent_we, ent_re, cell_has_room;
    logic [CELL_AW-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
    logic [ENT_W-1:0]   ent_wdata, ent_rdata;

    assign cell_has_room = (cnt_rdata < CNT_W'(CELL_CAPACITY));
    assign cnt_we    = (r_state == S_INIT) || ((r_state == S_INS_WR) && cell_has_room);
    assign cnt_waddr = (r_state == S_INIT) ? r_sweep : r_cell;
    assign cnt_wdata = (r_state == S_INIT) ? '0 : cnt_rdata + 1'b1;
    assign cnt_re    = (r_state == S_INS_RD) || (r_state == S_CNT_RD);
    assign cnt_raddr = (r_state == S_CNT_RD) ? q_cell : r_cell;
    assign ent_we    = (r_state == S_INS_WR) && cell_has_room;
    assign ent_waddr = ENT_AW'(r_cell) * ENT_AW'(CELL_CAPACITY) + ENT_AW'(cnt_rdata);
    assign ent_wdata = {r_oct, r_y, r_x, r_fidx};
    assign ent_re    = (r_state == S_ENT_RD);
    assign ent_raddr = ENT_AW'(r_cell) * ENT_AW'(CELL_CAPACITY) + ENT_AW'(r_j);

    fgbq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CELLS)) u_count_ram (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_re(cnt_re), .i_raddr(cnt_raddr), .o_rdata(cnt_rdata)
    );

    fgbq_ram #(.WIDTH(ENT_W), .DEPTH(ENT_DEPTH)) u_entry_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_re(ent_re), .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    // Entry check
    logic signed [15:0] e_x, e_y;
    logic [2:0]         e_oct;
    logic signed [16:0] ddx, ddy;
    logic [16:0]        adx, ady;
    logic               lvl_check, lvl_ok, hit;
    assign e_x   = ent_rdata[27:12];
    assign e_y   = ent_rdata[43:28];
    assign e_oct = ent_rdata[46:44];
    assign ddx   = {e_x[15], e_x} - {r_x[15], r_x};
    assign ddy   = {e_y[15], e_y} - {r_y[15], r_y};
    assign adx   = ddx[16] ? 17'(-ddx) : 17'(ddx);
    assign ady   = ddy[16] ? 17'(-ddy) : 17'(ddy);
    assign lvl_check = (r_min != 3'd0) || !r_max[3];
    assign lvl_ok = !lvl_check
                 || !((e_oct < r_min) || (!r_max[3] && ({1'b0, e_oct} > r_max)));
    assign hit = lvl_ok && (adx < r_rr) && (ady < r_rr);

    // Output register
    logic       r_ovalid, r_olast, r_otr, out_free, out_load;
    t_status    r_ost;
    logic [11:0] r_oidx;
    assign out_free = !r_ovalid || i_m_axis_tready;
    // The state machine puts a result into the output register in these cases.
    assign out_load = out_free && (((r_state == S_ENT_CHK) && hit && r_pend)
                                   || (r_state == S_FIN) || (r_state == S_EMIT));
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {4'd0, r_oidx};
    assign o_m_axis_tuser  = {r_otr, r_ost};
    assign o_m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_clr_reply <= 1'b0;
            r_ovalid    <= 1'b0;
            r_pend      <= 1'b0;
            r_k         <= '0;
        end else begin
            r_ovalid <= out_load || (r_ovalid && !i_m_axis_tready);
            case (r_state)
                S_INIT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == CELL_AW'(NUM_CELLS - 1)) begin
                        r_state <= r_clr_reply ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_fidx <= in_fidx;
                        r_x    <= in_x;
                        r_y    <= in_y;
                        r_rr   <= {2'b00, in_r};
                        r_oct  <= in_oct;
                        r_min  <= in_min;
                        r_max  <= in_max;
                        r_ins  <= (t_op'(i_s_axis_tuser) == OP_INSERT);
                        r_pend <= 1'b0;
                        r_k    <= '0;
                        r_dh_x <= {dx[16], dx} + {3'b000, in_r};
                        r_dh_y <= {dy[16], dy} + {3'b000, in_r};
                        if (t_op'(i_s_axis_tuser) == OP_QUERY) begin
                            r_dl_x <= {dx[16], dx} - {3'b000, in_r};
                            r_dl_y <= {dy[16], dy} - {3'b000, in_r};
                        end else begin
                            r_dl_x <= {dx[16], dx};
                            r_dl_y <= {dy[16], dy};
                        end
                        case (t_op'(i_s_axis_tuser))
                            OP_CLEAR: begin
                                r_sweep     <= '0;
                                r_clr_reply <= 1'b1;
                                r_st        <= ST_CLEARED;
                                r_state     <= S_INIT;
                            end
                            OP_INSERT: r_state <= S_MUL0;
                            OP_QUERY:  r_state <= S_MUL0;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL0: begin
                    r_pl_x  <= prod_x;
                    r_pl_y  <= prod_y;
                    r_state <= r_ins ? S_INS_CELL : S_MUL1;
                end
                S_MUL1: begin
                    r_ph_x  <= prod_x;
                    r_ph_y  <= prod_y;
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    r_x0 <= x0c[COL_W-1:0];
                    r_x1 <= x1c[COL_W-1:0];
                    r_y0 <= y0c[ROW_W-1:0];
                    r_y1 <= y1c[ROW_W-1:0];
                    r_ix <= x0c[COL_W-1:0];
                    r_iy <= y0c[ROW_W-1:0];
                    r_state <= range_empty ? S_FIN : S_CNT_RD;
                end
                S_INS_CELL: begin
                    r_cell <= ins_cell;
                    if (ins_out) begin
                        r_st    <= ST_OUTSIDE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    r_st    <= cell_has_room ? ST_INSERTED : ST_FULL;
                    r_state <= S_EMIT;
                end
                S_CNT_RD: begin
                    r_cell  <= q_cell;
                    r_state <= S_CNT_WAIT;
                end
                S_CNT_WAIT: begin
                    r_n <= cnt_rdata;
                    r_j <= '0;
                    if (cnt_rdata != '0) begin
                        r_state <= S_ENT_RD;
                    end else if (last_cell) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_CNT_RD;
                        if (r_iy == r_y1) begin
                            r_iy <= r_y0;
                            r_ix <= r_ix + 1'b1;
                        end else begin
                            r_iy <= r_iy + 1'b1;
                        end
                    end
                end
                S_ENT_RD: r_state <= S_ENT_CHK;
                S_ENT_CHK: begin
                    if (hit && (r_k == MCNT_W'(MAX_MATCHES))) begin
                        // One match beyond the limit: close the query with the held result.
                        if (out_free) begin
                            r_ost    <= ST_MATCH;
                            r_oidx   <= r_pidx;
                            r_olast  <= 1'b1;
                            r_otr    <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else if (!hit || !r_pend || out_free) begin
                        if (hit) begin
                            if (r_pend) begin
                                r_ost    <= ST_MATCH;
                                r_oidx   <= r_pidx;
                                r_olast  <= 1'b0;
                                r_otr    <= 1'b0;
                            end
                            r_pend <= 1'b1;
                            r_pidx <= ent_rdata[11:0];
                            r_k    <= r_k + 1'b1;
                        end
                        if (more_slots) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ENT_RD;
                        end else if (last_cell) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_CNT_RD;
                            if (r_iy == r_y1) begin
                                r_iy <= r_y0;
                                r_ix <= r_ix + 1'b1;
                            end else begin
                                r_iy <= r_iy + 1'b1;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ost    <= r_pend ? ST_MATCH : ST_NO_MATCH;
                        r_oidx   <= r_pend ? r_pidx : 12'd0;
                        r_olast  <= 1'b1;
                        r_otr    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ost       <= r_st;
                        r_oidx      <= 12'd0;
                        r_olast     <= 1'b1;
                        r_otr       <= 1'b0;
                        r_clr_reply <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FGBQ_ASSERT(a_match_count_bound, i_clk, i_rst_n, r_k <= MCNT_W'(MAX_MATCHES))
    `FGBQ_ASSERT_IMPLY(a_slot_in_cell, i_clk, i_rst_n, r_state == S_ENT_CHK, r_j < r_n)
    `FGBQ_ASSERT_IMPLY(a_count_write_bound, i_clk, i_rst_n, cnt_we, cnt_wdata <= CNT_W'(CELL_CAPACITY))
    `FGBQ_ASSERT_IMPLY(a_walk_in_range, i_clk, i_rst_n, r_state == S_CNT_RD, (r_ix <= r_x1) && (r_iy <= r_y1) && (r_iy >= r_y0))
    `FGBQ_ASSERT_IMPLY(a_truncate_needs_pend, i_clk, i_rst_n, r_k != '0, r_pend)

endmodule

### sim/fgbq_checker.sv
`timescale 1ns / 1ps

module fgbq_checker import fgbq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // feature_index[11:0], x_pos[27:12], y_pos[43:28], radius[58:44], octave[61:59],
    // min_level[64:62], max_level[68:65], zero pad[71:69]
    input  logic [71:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // match_index[11:0], zero pad[15:12]
    input  logic [15:0] i_m_axis_tdata,
    // status[2:0], truncated[3]
    input  logic [3:0]  i_m_axis_tuser,
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [11:0]        idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [2:0]         oct;
    } t_grid_entry;

    typedef struct {
        t_status     st;
        logic [11:0] idx;
        logic        last;
        logic        trunc;
    } t_grid_result;

    logic signed [15:0] org_x, org_y;
    logic [15:0]        inv_w, inv_h;
    int                 cell_fill [NUM_CELLS];
    t_grid_entry        cell_slot [NUM_CELLS * CELL_CAPACITY];
    t_grid_result       results_due [$];

    assign o_pending = results_due.size();

    // Arithmetic shift of a signed value rounds toward minus infinity.
    function automatic longint floor20(longint p);
        return p >>> 20;
    endfunction

    function automatic longint ceil20(longint p);
        return -((-p) >>> 20);
    endfunction

    task automatic push_result(t_status st, logic [11:0] idx, logic last, logic trunc);
        t_grid_result r;
        r.st = st;
        r.idx = idx;
        r.last = last;
        r.trunc = trunc;
        results_due = {results_due, r};
    endtask

    task automatic predict_insert(logic [11:0] fidx, logic signed [15:0] px,
                                  logic signed [15:0] py, logic [2:0] oct);
        longint cx, cy;
        int     cell_no;
        cx = floor20((longint'(px) - longint'(org_x)) * longint'(inv_w) + 524288);
        cy = floor20((longint'(py) - longint'(org_y)) * longint'(inv_h) + 524288);
        if (cx < 0 || cx >= GRID_COLS || cy < 0 || cy >= GRID_ROWS) begin
            push_result(ST_OUTSIDE, '0, 1'b1, 1'b0);
        end else begin
            cell_no = int'(cx) * GRID_ROWS + int'(cy);
            if (cell_fill[cell_no] >= CELL_CAPACITY) begin
                push_result(ST_FULL, '0, 1'b1, 1'b0);
            end else begin
                cell_slot[cell_no * CELL_CAPACITY + cell_fill[cell_no]] = '{fidx, px, py, oct};
                cell_fill[cell_no]++;
                push_result(ST_INSERTED, '0, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic predict_query(logic signed [15:0] qx, logic signed [15:0] qy,
                                 logic [14:0] rad, logic [2:0] mn, logic signed [3:0] mx);
        longint       dx, dy, r, c0, c1, w0, w1, ddx, ddy;
        int           cell_no, k, mxi;
        bit           filt, stop;
        t_grid_entry  e;
        t_grid_result hits [$];
        r = rad;
        mxi = mx;
        dx = longint'(qx) - longint'(org_x);
        dy = longint'(qy) - longint'(org_y);
        c0 = floor20((dx - r) * longint'(inv_w));
        c1 = ceil20((dx + r) * longint'(inv_w));
        w0 = floor20((dy - r) * longint'(inv_h));
        w1 = ceil20((dy + r) * longint'(inv_h));
        if (c0 < 0) c0 = 0;
        if (c1 > GRID_COLS - 1) c1 = GRID_COLS - 1;
        if (w0 < 0) w0 = 0;
        if (w1 > GRID_ROWS - 1) w1 = GRID_ROWS - 1;
        if (c0 >= GRID_COLS || c1 < 0 || w0 >= GRID_ROWS || w1 < 0 || c0 > c1 || w0 > w1) begin
            push_result(ST_NO_MATCH, '0, 1'b1, 1'b0);
            return;
        end
        filt = (mn > 0) || (mxi >= 0);
        stop = 1'b0;
        k = 0;
        for (longint ix = c0; ix <= c1 && !stop; ix++) begin
            for (longint iy = w0; iy <= w1 && !stop; iy++) begin
                cell_no = int'(ix) * GRID_ROWS + int'(iy);
                for (int j = 0; j < cell_fill[cell_no] && !stop; j++) begin
                    e = cell_slot[cell_no * CELL_CAPACITY + j];
                    if (filt && (e.oct < mn || (mxi >= 0 && int'(e.oct) > mxi)))
                        continue;
                    ddx = longint'(e.x) - longint'(qx);
                    ddy = longint'(e.y) - longint'(qy);
                    if (ddx < 0) ddx = -ddx;
                    if (ddy < 0) ddy = -ddy;
                    if (ddx < r && ddy < r) begin
                        if (k >= MAX_MATCHES) begin
                            stop = 1'b1;
                        end else begin
                            hits = {hits, t_grid_result'{ST_MATCH, e.idx, 1'b0, 1'b0}};
                            k++;
                        end
                    end
                end
            end
        end
        if (k == 0) begin
            push_result(ST_NO_MATCH, '0, 1'b1, 1'b0);
        end else begin
            hits[k - 1].last = 1'b1;
            hits[k - 1].trunc = stop;
            foreach (hits[i]) results_due = {results_due, hits[i]};
        end
    endtask

    always @(posedge i_clk) begin
        t_grid_result exp_r;
        if (!i_rst_n) begin
            org_x = '0;
            org_y = '0;
            inv_w = 16'd6554;
            inv_h = 16'd6554;
            foreach (cell_fill[i]) cell_fill[i] = 0;
            results_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_addr))
                    REG_ORIGIN_X:   org_x = i_cfg_data;
                    REG_ORIGIN_Y:   org_y = i_cfg_data;
                    REG_CELL_W_INV: inv_w = i_cfg_data;
                    REG_CELL_H_INV: inv_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                case (t_op'(i_s_axis_tuser))
                    OP_CLEAR: begin
                        foreach (cell_fill[i]) cell_fill[i] = 0;
                        push_result(ST_CLEARED, '0, 1'b1, 1'b0);
                    end
                    OP_INSERT: predict_insert(i_s_axis_tdata[11:0], i_s_axis_tdata[27:12],
                                              i_s_axis_tdata[43:28], i_s_axis_tdata[61:59]);
                    OP_QUERY: predict_query(i_s_axis_tdata[27:12], i_s_axis_tdata[43:28],
                                            i_s_axis_tdata[58:44], i_s_axis_tdata[64:62],
                                            i_s_axis_tdata[68:65]);
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result status %0d index %0d last %0b trunc %0b",
                             $time, i_m_axis_tuser[2:0], i_m_axis_tdata[11:0],
                             i_m_axis_tlast, i_m_axis_tuser[3]);
                    o_fail_count++;
                end else begin
                    exp_r = results_due.pop_front();
                    if (i_m_axis_tuser[2:0] !== exp_r.st || i_m_axis_tdata[11:0] !== exp_r.idx
                        || i_m_axis_tlast !== exp_r.last || i_m_axis_tuser[3] !== exp_r.trunc)
                    begin
                        $display({"%0t: expected st %0d idx %0d last %0b trunc %0b,",
                                  " got st %0d idx %0d last %0b trunc %0b"},
                                 $time, exp_r.st, exp_r.idx, exp_r.last, exp_r.trunc,
                                 i_m_axis_tuser[2:0], i_m_axis_tdata[11:0],
                                 i_m_axis_tlast, i_m_axis_tuser[3]);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fgbq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    int          fail_count, pending;
    int          snd_idle_pct = 26, rcv_idle_pct = 85;
    int          items_sent = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    feature_grid_bin_and_area_query_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast)
    );

    fgbq_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tuser(m_tuser), .i_m_axis_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= 600;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic logic [15:0] sat16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return 16'h8000;
        return 16'(v);
    endfunction

    task automatic send(t_op op, logic [11:0] fidx, logic [15:0] px, logic [15:0] py,
                        logic [14:0] rad, logic [2:0] oct, logic [2:0] mn, logic [3:0] mx);
        if (items_sent < 50) begin
            snd_idle_pct = 26;
            rcv_idle_pct = 85;
        end else if (items_sent < 100) begin
            snd_idle_pct = 85;
            rcv_idle_pct = 26;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, mx, mn, oct, rad, py, px, fidx};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_reg(t_reg idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Waits until the block is idle, then loads a new grid geometry.
    task automatic set_geometry(logic [15:0] ox, logic [15:0] oy, logic [15:0] iw,
                                logic [15:0] ih);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_W_INV, iw);
        write_reg(REG_CELL_H_INV, ih);
        cfg_we <= 1'b0;
    endtask

    task automatic noise_item();
        send(t_op'($urandom_range(3)), 12'($urandom), 16'($urandom), 16'($urandom),
             15'($urandom), 3'($urandom), 3'($urandom), 4'($urandom));
    endtask

    // Inserts and queries around one spot so that queries find stored features.
    task automatic local_mix(int cx, int cy, int spread, int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 55)
                send(OP_INSERT, 12'($urandom),
                     sat16(cx + $urandom_range(2 * spread) - spread),
                     sat16(cy + $urandom_range(2 * spread) - spread),
                     '0, 3'($urandom), '0, '0);
            else if (kind < 85)
                send(OP_QUERY, 12'($urandom),
                     sat16(cx + $urandom_range(2 * spread) - spread),
                     sat16(cy + $urandom_range(2 * spread) - spread),
                     15'($urandom_range(2 * spread)), '0,
                     3'($urandom_range(2)), 4'($urandom_range(4) + 3));
            else
                noise_item();
        end
    endtask

    initial begin
        int ox, oy;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset geometry.
        send(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        send(OP_INSERT, 12'hFFF, 16'sd0, 16'sd0, '0, 3'd7, '0, '0);
        send(OP_INSERT, 12'd1, 16'h8000, 16'sd0, '0, '0, '0, '0);
        send(OP_INSERT, 12'd2, 16'sd32767, 16'sd0, '0, '0, '0, '0);
        send(OP_INSERT, 12'd3, 16'sd0, 16'sd32767, '0, '0, '0, '0);
        for (int i = 0; i < 8; i++)
            send(OP_INSERT, 12'(10 + i), 16'(5 * i), 16'(3 * i), '0, 3'(i), '0, '0);
        send(OP_QUERY, '0, 16'sd0, 16'sd0, 15'd0, '0, '0, 4'hF);
        send(OP_QUERY, '0, 16'sd0, 16'sd0, 15'h7FFF, '0, 3'd0, 4'hF);
        send(OP_QUERY, '0, 16'sd10, 16'sd10, 15'd40, '0, 3'd7, 4'd7);
        send(OP_QUERY, '0, 16'sd10, 16'sd10, 15'd40, '0, 3'd0, 4'd0);
        send(OP_QUERY, '0, 16'sd10, 16'sd10, 15'd40, '0, 3'd2, 4'd5);
        send(OP_QUERY, '0, 16'h8000, 16'h8000, 15'd0, '0, '0, 4'hF);
        send(OP_QUERY, '0, 16'sd32767, 16'sd32767, 15'd0, '0, '0, 4'hF);
        send(OP_NOP, 12'hFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 3'd7, 3'd7, 4'hF);

        // Dense patch under a long receiver hold-off, then a query that truncates.
        set_geometry(16'sd0, 16'sd0, 16'd6554, 16'd6554);
        send(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        hold_go <= 1'b1;
        for (int i = 0; i < 72; i++)
            send(OP_INSERT, 12'($urandom), 16'($urandom_range(2079, 1600)),
                 16'($urandom_range(2079, 1600)), '0, 3'($urandom), '0, '0);
        hold_go <= 1'b0;
        send(OP_QUERY, '0, 16'sd1840, 16'sd1840, 15'd600, '0, 3'd0, 4'hF);
        local_mix(1840, 1840, 400, 3);

        // Finest cells at the far negative corner.
        set_geometry(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        local_mix(-32768 + 30, -32768 + 25, 30, 3);

        // Zero inverse sizes fold everything into the first cell.
        set_geometry(16'sd32767, 16'sd32767, 16'd0, 16'd0);
        send(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        local_mix(0, 0, 3000, 3);

        ox = $urandom_range(4000) - 2000;
        oy = $urandom_range(4000) - 2000;
        set_geometry(16'(ox), 16'(oy), 16'($urandom_range(20000, 2000)),
                     16'($urandom_range(20000, 2000)));
        send(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        local_mix(ox + 600, oy + 600, 500, 4);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
